>>> rtl/sre_pkg.sv
// sre_pkg: shared widths, constants, state and result word types, Sobel and root helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sre_pkg;
    localparam int MaxWidth = 1024;
    localparam int AddrW    = $clog2(MaxWidth);
    localparam logic [16:0] SatLimit = 17'd65281;
    localparam logic [7:0]  SatValue = 8'd255;

    typedef enum logic { t_op_pixel = 1'b0, t_op_drain = 1'b1 } t_op;

    typedef enum logic [2:0] {
        t_idle, t_pread, t_pcalc, t_dread, t_dcalc, t_square, t_root, t_emit
    } t_state;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_result;

    // Sobel per channel on 8-bit taps; returns the squared magnitude sum, saturated at SatLimit.
    function automatic logic [16:0] sobel_sq(input logic [7:0] a0, input logic [7:0] a1,
        input logic [7:0] a2, input logic [7:0] b0, input logic [7:0] b2,
        input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2);
        logic signed [11:0] gx;
        logic signed [11:0] gy;
        logic signed [21:0] gx_w;
        logic signed [21:0] gy_w;
        logic [21:0] s;
        gx = $signed({4'd0, a2}) + $signed({3'd0, b2, 1'b0}) + $signed({4'd0, c2})
           - $signed({4'd0, a0}) - $signed({3'd0, b0, 1'b0}) - $signed({4'd0, c0});
        gy = $signed({4'd0, c0}) + $signed({3'd0, c1, 1'b0}) + $signed({4'd0, c2})
           - $signed({4'd0, a0}) - $signed({3'd0, a1, 1'b0}) - $signed({4'd0, a2});
        gx_w = 22'(gx);
        gy_w = 22'(gy);
        s = gx_w * gx_w + gy_w * gy_w;
        if (s >= 22'(SatLimit)) sobel_sq = SatLimit;
        else sobel_sq = s[16:0];
    endfunction

    // One bit of the integer root: keep bit b when the trial square still fits.
    function automatic logic [7:0] root_step(input logic [16:0] s, input logic [7:0] n,
        input logic [2:0] b);
        logic [7:0] t;
        t = n | (8'd1 << b);
        if (({9'd0, t} * {9'd0, t}) <= s) root_step = t;
        else root_step = n;
    endfunction

    // Round the floor root to nearest and saturate.
    function automatic logic [7:0] root_round(input logic [16:0] s, input logic [7:0] n);
        logic [16:0] nn;
        nn = ({9'd0, n} * {9'd0, n}) + {9'd0, n};
        if (s >= SatLimit) root_round = SatValue;
        else if (s > nn) root_round = n + 8'd1;
        else root_round = n;
    endfunction
endpackage
`default_nettype wire

>>> rtl/sre_stream_if.sv
// sre_stream_if: valid/ready channel interfaces for input, result and configuration words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface sre_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    modport source (output valid, op, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, op, red_in, green_in, blue_in, output ready);
endinterface

interface sre_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
    modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

interface sre_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/sobel_rgb_edge_magnitude_core.sv
// Top level of the streaming RGB Sobel magnitude block.
// Depends on sre_pkg and the channel interfaces in sre_stream_if.
//
// Usage: send pixel words (op=0) in raster order, then drain words (op=1)
// to flush the last row, one result each. Configure width (index 0) and
// height (index 1) only while idle. Results leave on the result channel.
// A pixel word reads both line memories, updates the window, squares the
// Sobel sums, runs the rounded root one bit per cycle and writes up to two
// results into a two-entry output queue. A drain word reads three memory
// columns through the single read port before the same steps.
// The next word is taken only when the machine is idle and the queue is
// empty.
// Reset clears counters, window and queue; line memories are not cleared.
// A stalled receiver holds the queue; new words wait until it has drained.
`timescale 1ns / 1ps
`default_nettype none
module sobel_rgb_edge_magnitude_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sre_in_if.sink      in_ch,
    sre_out_if.source   out_ch,
    sre_cfg_if.sink     cfg_ch
);
    localparam int AW = sre_pkg::AddrW;

    typedef sre_pkg::t_result t_result_q;

    logic [23:0] r_mem_a [sre_pkg::MaxWidth];
    logic [23:0] r_mem_b [sre_pkg::MaxWidth];
    logic [23:0] r_rd_a, r_rd_b;

    logic [10:0] r_width;
    logic [15:0] r_height;
    logic [15:0] r_row;
    logic [AW-1:0] r_col, r_drain;
    logic [23:0] r_win [3][3];
    sre_pkg::t_state r_state, n_state;
    logic [23:0] r_pix;
    logic [1:0]  r_dstep;
    logic [23:0] r_da [3], r_db [3];
    logic [23:0] r_p [2][3][3];
    logic [16:0] r_sq [2][3];
    logic [7:0]  r_rt [2][3];
    logic [2:0]  r_rbit;
    logic [1:0]  r_pcnt;
    logic        r_plast;
    t_result_q   r_q [2];
    logic [1:0]  r_qcnt;
    logic        r_qhead;

    // effective bounds
    logic [10:0] w_eff;
    logic [15:0] h_eff;
    assign w_eff = (r_width == 11'd0) ? 11'd1 :
                   (r_width > 11'(sre_pkg::MaxWidth)) ? 11'(sre_pkg::MaxWidth) : r_width;
    assign h_eff = (r_height == 16'd0) ? 16'd1 : r_height;
    logic drain_phase;
    assign drain_phase = r_row >= h_eff;

    logic in_fire, cfg_fire, out_fire;
    assign in_ch.ready = (r_state == sre_pkg::t_idle) && (r_qcnt == 2'd0);
    assign in_fire = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign cfg_fire = cfg_ch.valid;
    assign out_ch.valid = r_qcnt != 2'd0;
    assign out_fire = out_ch.valid && out_ch.ready;
    always_comb begin
        out_ch.red_out    = r_q[r_qhead].red;
        out_ch.green_out  = r_q[r_qhead].green;
        out_ch.blue_out   = r_q[r_qhead].blue;
        out_ch.frame_last = r_q[r_qhead].last;
    end

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] d_next;
    assign d_next = r_drain + AW'(1);
    always_comb begin
        rd_addr = r_col;
        if (r_state == sre_pkg::t_dread) begin
            case (r_dstep)
                2'd0:    rd_addr = r_drain - AW'(1);
                2'd1:    rd_addr = r_drain;
                default: rd_addr = d_next;
            endcase
        end
    end

    logic col_last, drn_last;
    assign col_last = ({1'b0, r_col} + 11'd1) >= w_eff;
    assign drn_last = ({1'b0, r_drain} + 11'd1) >= w_eff;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sre_pkg::t_idle: if (in_fire) begin
                if (in_ch.op == sre_pkg::t_op_pixel)
                    n_state = drain_phase ? sre_pkg::t_idle : sre_pkg::t_pread;
                else
                    n_state = drain_phase ? sre_pkg::t_dread : sre_pkg::t_idle;
            end
            sre_pkg::t_pread:  n_state = sre_pkg::t_pcalc;
            sre_pkg::t_pcalc:  n_state = sre_pkg::t_square;
            sre_pkg::t_dread:  if (r_dstep == 2'd3) n_state = sre_pkg::t_dcalc;
            sre_pkg::t_dcalc:  n_state = sre_pkg::t_square;
            sre_pkg::t_square: n_state = sre_pkg::t_root;
            sre_pkg::t_root:   if (r_rbit == 3'd0) n_state = sre_pkg::t_emit;
            sre_pkg::t_emit:   n_state = sre_pkg::t_idle;
            default:           n_state = sre_pkg::t_idle;
        endcase
    end

    // memory: one read and one write port each
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem_a[rd_addr];
        r_rd_b <= r_mem_b[rd_addr];
        if (r_state == sre_pkg::t_pcalc) begin
            r_mem_a[r_col] <= r_pix;
            r_mem_b[r_col] <= r_rd_a;
        end
    end

    logic [23:0] col_new [3];
    logic [23:0] w2 [3][3];
    logic top_ok;
    assign top_ok = r_row != 16'd1;
    always_comb begin
        col_new[0] = r_rd_b; col_new[1] = r_rd_a; col_new[2] = r_pix;
        for (int i = 0; i < 3; i++) begin
            w2[i][0] = r_win[i][1]; w2[i][1] = r_win[i][2]; w2[i][2] = col_new[i];
        end
    end

    // squared Sobel sums of both pending windows, channel 0 is red
    logic [16:0] sq_new [2][3];
    always_comb begin
        for (int k = 0; k < 2; k++)
            for (int c = 0; c < 3; c++)
                sq_new[k][c] = sre_pkg::sobel_sq(
                    r_p[k][0][0][16-8*c +: 8], r_p[k][0][1][16-8*c +: 8],
                    r_p[k][0][2][16-8*c +: 8], r_p[k][1][0][16-8*c +: 8],
                    r_p[k][1][2][16-8*c +: 8], r_p[k][2][0][16-8*c +: 8],
                    r_p[k][2][1][16-8*c +: 8], r_p[k][2][2][16-8*c +: 8]);
    end

    t_result_q res [2];
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            res[k].red   = sre_pkg::root_round(r_sq[k][0], r_rt[k][0]);
            res[k].green = sre_pkg::root_round(r_sq[k][1], r_rt[k][1]);
            res[k].blue  = sre_pkg::root_round(r_sq[k][2], r_rt[k][2]);
            res[k].last  = (k == 0) ? r_plast : 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sre_pkg::t_idle; r_width <= 11'd640; r_height <= 16'd480;
            r_row <= '0; r_col <= '0; r_drain <= '0; r_dstep <= '0; r_rbit <= '0;
            r_pcnt <= '0; r_plast <= 1'b0; r_qcnt <= '0; r_qhead <= 1'b0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) r_win[i][j] <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_fire) begin
                if (cfg_ch.index == 1'b0) r_width <= cfg_ch.data[10:0];
                else r_height <= cfg_ch.data;
            end
            if (in_fire) begin
                r_pix <= {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
                r_dstep <= '0;
            end
            if (r_state == sre_pkg::t_dread) begin
                r_dstep <= r_dstep + 2'd1;
                // data from the previous step's address lands now
                if (r_dstep != 2'd0) begin
                    r_da[r_dstep - 2'd1] <= r_rd_a;
                    r_db[r_dstep - 2'd1] <= r_rd_b;
                end
            end
            if (r_state == sre_pkg::t_pcalc) begin
                r_plast <= 1'b0;
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) r_win[i][j] <= w2[i][j];
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) begin
                        // in column zero only the row end result exists; it takes slot zero
                        if (r_col == '0)
                            r_p[0][i][j] <= ((i == 0 && !top_ok) || j != 1) ? 24'd0 : w2[i][2];
                        else
                            r_p[0][i][j] <= ((i == 0 && !top_ok) ||
                                             (j == 0 && r_col == AW'(1))) ? 24'd0 : w2[i][j];
                        r_p[1][i][j] <= ((i == 0 && !top_ok) || j == 2 ||
                                         (j == 0 && r_col == '0)) ? 24'd0 :
                                        w2[i][j+((j==2)?0:1)];
                    end
                if (r_row == 16'd0) r_pcnt <= 2'd0;
                else if (r_col != '0 && col_last) r_pcnt <= 2'd2;
                else if (r_col != '0 || col_last) r_pcnt <= 2'd1;
                else r_pcnt <= 2'd0;
                if (col_last) begin
                    r_col <= '0; r_row <= r_row + 16'd1;
                    if (r_row + 16'd1 >= h_eff) r_drain <= '0;
                end else r_col <= r_col + AW'(1);
            end
            if (r_state == sre_pkg::t_dcalc) begin
                r_pcnt <= 2'd1; r_plast <= drn_last;
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) begin
                        logic [23:0] v;
                        v = (i == 0) ? r_db[j] : r_da[j];
                        if (i == 2 || (i == 0 && h_eff == 16'd1) ||
                            (j == 0 && r_drain == '0) || (j == 2 && drn_last))
                            v = 24'd0;
                        r_p[0][i][j] <= v;
                    end
                if (drn_last) begin
                    r_row <= '0; r_col <= '0; r_drain <= '0;
                end else r_drain <= d_next;
            end
            // square the sums, then resolve the root one bit per cycle from the top
            if (r_state == sre_pkg::t_square) begin
                r_rbit <= 3'd7;
                for (int k = 0; k < 2; k++)
                    for (int c = 0; c < 3; c++) begin
                        r_sq[k][c] <= sq_new[k][c];
                        r_rt[k][c] <= 8'd0;
                    end
            end
            if (r_state == sre_pkg::t_root) begin
                r_rbit <= r_rbit - 3'd1;
                for (int k = 0; k < 2; k++)
                    for (int c = 0; c < 3; c++)
                        r_rt[k][c] <= sre_pkg::root_step(r_sq[k][c], r_rt[k][c], r_rbit);
            end
            // queue: write on emit, pop on handshake
            if (r_state == sre_pkg::t_emit) begin
                r_q[0] <= res[0]; r_q[1] <= res[1];
                r_qhead <= 1'b0; r_qcnt <= r_pcnt;
            end else if (out_fire) begin
                r_qhead <= 1'b1; r_qcnt <= r_qcnt - 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != sre_pkg::t_idle) |-> !in_ch.ready) else $error("accept while busy");
    a_qcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= 2'd2) else $error("queue overflow");
    a_emit_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sre_pkg::t_emit) |-> (r_qcnt == 2'd0)) else $error("emit onto full queue");
`endif
endmodule
`default_nettype wire

>>> dv/tb_sobel_rgb_edge_magnitude_core.sv
// Self-checking testbench for sobel_rgb_edge_magnitude_core: random and directed frames.
// Depends on sre_pkg, the channel interfaces in sre_stream_if and the core itself.
`timescale 1ns / 1ps
module tb_sobel_rgb_edge_magnitude_core;

    localparam int CycleLimit   = 3000000;
    localparam int SettleCycles = 20;
    localparam int WideRow      = 200;
    localparam int ItemTarget   = 800;
    localparam int CalmAfter    = 650;
    localparam bit RegWidth     = 1'b0;
    localparam bit RegHeight    = 1'b1;

    typedef logic [23:0] t_taps [3][3];

    // Edge magnitude predictor plus the queue of result words still owed.
    class sobel_scoreboard;
        sre_pkg::t_result owed_q[$];
        logic [23:0] row_above [sre_pkg::MaxWidth];
        logic [23:0] row_two_above [sre_pkg::MaxWidth];
        t_taps       win;
        int unsigned rows, cols, drains;
        int unsigned width_reg, height_reg;
        int          errors;
        int          checked;

        function new();
            for (int i = 0; i < sre_pkg::MaxWidth; i++) begin
                row_above[i] = '0;
                row_two_above[i] = '0;
            end
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) win[i][j] = '0;
            rows = 0;
            cols = 0;
            drains = 0;
            width_reg = 640;
            height_reg = 480;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(bit idx, logic [15:0] d);
            if (idx == RegWidth) width_reg = d[10:0];
            else height_reg = d;
        endfunction

        function int unsigned eff_width();
            if (width_reg < 1) return 1;
            if (width_reg > sre_pkg::MaxWidth) return sre_pkg::MaxWidth;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            return (height_reg < 1) ? 1 : height_reg;
        endfunction

        // Rounded root of gx^2+gy^2, saturated at 255.
        function logic [7:0] edge_mag(int gx, int gy);
            int s;
            int r;
            s = gx * gx + gy * gy;
            if (s >= 65281) return 8'd255;
            r = 0;
            while ((r + 1) * (r + 1) <= s) r++;
            if (s > r * r + r) r++;
            return 8'(r);
        endfunction

        function void owe_result(t_taps p, bit top_ok, bit bot_ok, bit left_ok,
                                 bit right_ok, bit last);
            sre_pkg::t_result res;
            int v [3][3];
            int gx, gy, sh;
            logic [7:0] mag [3];
            for (int i = 0; i < 3; i++) begin
                if (!top_ok) p[0][i] = '0;
                if (!bot_ok) p[2][i] = '0;
                if (!left_ok) p[i][0] = '0;
                if (!right_ok) p[i][2] = '0;
            end
            for (int ch = 0; ch < 3; ch++) begin
                sh = 16 - 8 * ch;
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) v[i][j] = int'((p[i][j] >> sh) & 24'hFF);
                gx = (v[0][2] + 2 * v[1][2] + v[2][2]) - (v[0][0] + 2 * v[1][0] + v[2][0]);
                gy = (v[2][0] + 2 * v[2][1] + v[2][2]) - (v[0][0] + 2 * v[0][1] + v[0][2]);
                mag[ch] = edge_mag(gx, gy);
            end
            res.red = mag[0];
            res.green = mag[1];
            res.blue = mag[2];
            res.last = last;
            owed_q.push_back(res);
        endfunction

        function void note_input(sre_pkg::t_op op, logic [7:0] r, logic [7:0] g,
                                 logic [7:0] b);
            int unsigned w, h, x, d;
            bit last, top_ok;
            logic [23:0] pix;
            logic [23:0] col [3];
            t_taps p;
            w = eff_width();
            h = eff_height();
            if (op == sre_pkg::t_op_pixel) begin
                if (rows >= h) return;
                pix = {r, g, b};
                x = cols % sre_pkg::MaxWidth;
                last = (x + 1 >= w);
                col[0] = row_two_above[x];
                col[1] = row_above[x];
                col[2] = pix;
                for (int i = 0; i < 3; i++) begin
                    win[i][0] = win[i][1];
                    win[i][1] = win[i][2];
                    win[i][2] = col[i];
                end
                row_two_above[x] = row_above[x];
                row_above[x] = pix;
                if (rows >= 1) begin
                    top_ok = (rows - 1) != 0;
                    if (x >= 1) owe_result(win, top_ok, 1'b1, (x - 1) != 0, 1'b1, 1'b0);
                    if (last) begin
                        for (int i = 0; i < 3; i++) begin
                            p[i][0] = win[i][1];
                            p[i][1] = win[i][2];
                            p[i][2] = '0;
                        end
                        owe_result(p, top_ok, 1'b1, x != 0, 1'b0, 1'b0);
                    end
                end
                if (last) begin
                    cols = 0;
                    rows = (rows + 1) & 32'hFFFF;
                    if (rows >= h) drains = 0;
                end else begin
                    cols = x + 1;
                end
            end else begin
                if (rows < h) return;
                d = drains % sre_pkg::MaxWidth;
                last = (d + 1 >= w);
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) p[i][j] = '0;
                if (d >= 1) begin
                    p[0][0] = row_two_above[d - 1];
                    p[1][0] = row_above[d - 1];
                end
                p[0][1] = row_two_above[d];
                p[1][1] = row_above[d];
                if (!last && d + 1 < sre_pkg::MaxWidth) begin
                    p[0][2] = row_two_above[d + 1];
                    p[1][2] = row_above[d + 1];
                end
                owe_result(p, h > 1, 1'b0, d != 0, !last, last);
                if (last) begin
                    rows = 0;
                    cols = 0;
                    drains = 0;
                end else begin
                    drains = d + 1;
                end
            end
        endfunction

        function void check_result(sre_pkg::t_result got);
            sre_pkg::t_result exp_res;
            checked++;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word r=%0d g=%0d b=%0d last=%0b", $time,
                         got.red, got.green, got.blue, got.last);
                return;
            end
            exp_res = owed_q.pop_front();
            if (got.red !== exp_res.red) begin
                errors++;
                $display("%0t: red mismatch expected %0d actual %0d", $time,
                         exp_res.red, got.red);
            end
            if (got.green !== exp_res.green) begin
                errors++;
                $display("%0t: green mismatch expected %0d actual %0d", $time,
                         exp_res.green, got.green);
            end
            if (got.blue !== exp_res.blue) begin
                errors++;
                $display("%0t: blue mismatch expected %0d actual %0d", $time,
                         exp_res.blue, got.blue);
            end
            if (got.last !== exp_res.last) begin
                errors++;
                $display("%0t: frame_last mismatch expected %0b actual %0b", $time,
                         exp_res.last, got.last);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sre_in_if  in_ch ();
    sre_out_if out_ch ();
    sre_cfg_if cfg_ch ();

    sobel_rgb_edge_magnitude_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch)
    );

    sobel_scoreboard edge_sb;
    bit              idling_on;
    int              cycles;
    int              frames_done;
    int              items_sent;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("[sobel_rgb_edge_magnitude_core] ERROR");
            $finish;
        end
    end

    // Sample both channels at the falling edge, where inputs and outputs are
    // settled; a word seen with valid and ready here is taken at the next rise.
    always @(negedge i_clk) begin
        sre_pkg::t_result got;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                edge_sb.note_input(sre_pkg::t_op'(in_ch.op), in_ch.red_in, in_ch.green_in,
                                   in_ch.blue_in);
            if (out_ch.valid && out_ch.ready) begin
                got.red = out_ch.red_out;
                got.green = out_ch.green_out;
                got.blue = out_ch.blue_out;
                got.last = out_ch.frame_last;
                edge_sb.check_result(got);
            end
        end
    end

    // Receiver: hold ready low in random bursts while idling is enabled.
    initial begin
        out_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (idling_on && $urandom_range(0, 9) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Send one word; leave valid high so back-to-back words need no toggle.
    task automatic send_word(sre_pkg::t_op op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.red_in <= r;
        in_ch.green_in <= g;
        in_ch.blue_in <= b;
        do @(negedge i_clk); while (!in_ch.ready);
        @(posedge i_clk);
        items_sent++;
    endtask

    // Drop valid and hold until every owed word is back, then let the pipe settle.
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        while (edge_sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(bit idx, logic [15:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= d;
        do @(negedge i_clk); while (!cfg_ch.ready);
        edge_sb.write_reg(idx, d);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [7:0] chan_value(int style);
        case (style)
            0: return 8'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: return 8'd255;
        endcase
    endfunction

    // One full frame: program size, stream pixels, flush the last row.
    // Style 0 is random content, 1 is a black/white mix, 2 is all white.
    task automatic run_frame(int w, int h, int style, bit stray);
        wait_quiet();
        write_reg(RegWidth, 16'(w));
        write_reg(RegHeight, 16'(h));
        // a drain before the frame is in its flush phase must be dropped
        if (stray) send_word(sre_pkg::t_op_drain, 8'hA5, 8'h5A, 8'hFF);
        for (int i = 0; i < w * h; i++)
            send_word(sre_pkg::t_op_pixel, chan_value(style), chan_value(style),
                      chan_value(style));
        for (int i = 0; i < w; i++) begin
            // a pixel in the flush phase must be dropped
            if (stray && i == 0) send_word(sre_pkg::t_op_pixel, 8'hFF, 8'h00, 8'hFF);
            send_word(sre_pkg::t_op_drain, chan_value(0), chan_value(0), chan_value(0));
        end
        frames_done++;
    endtask

    initial begin
        edge_sb = new();
        idling_on = 1'b0;
        cycles = 0;
        frames_done = 0;
        items_sent = 0;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.op <= sre_pkg::t_op_pixel;
        in_ch.red_in <= '0;
        in_ch.green_in <= '0;
        in_ch.blue_in <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= RegWidth;
        cfg_ch.data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: corners, saturation, single pixel frame, dropped words.
        run_frame(3, 3, 1, 1'b1);
        run_frame(1, 1, 2, 1'b0);
        run_frame(2, 1, 2, 1'b1);
        run_frame(2, 2, 1, 1'b0);

        // Tallest height: start a one-wide frame, then shrink the height so
        // the row count is already past it and the flush begins at once.
        wait_quiet();
        write_reg(RegWidth, 16'd1);
        write_reg(RegHeight, 16'hFFFF);
        for (int i = 0; i < 3; i++) send_word(sre_pkg::t_op_pixel, chan_value(0), 8'hFF, 8'h00);
        wait_quiet();
        write_reg(RegHeight, 16'd2);
        send_word(sre_pkg::t_op_drain, 8'h00, 8'h00, 8'h00);
        frames_done++;

        // Wide row, with stalls on both sides.
        idling_on = 1'b1;
        run_frame(WideRow, 1, 0, 1'b0);

        // Random frames, mostly small; the tail runs at full rate.
        while (items_sent < ItemTarget) begin
            if (items_sent > CalmAfter) idling_on = 1'b0;
            if ($urandom_range(0, 15) == 0)
                run_frame($urandom_range(13, 24), $urandom_range(1, 3), 0,
                          $urandom_range(0, 3) == 0);
            else
                run_frame($urandom_range(1, 12), $urandom_range(1, 6),
                          $urandom_range(0, 4) == 0 ? 1 : 0, $urandom_range(0, 3) == 0);
        end

        wait_quiet();
        $display("Covered %0d frames (widths 1 to %0d, heights 1 to 65535), %0d words in, %0d out.",
                 frames_done, WideRow, items_sent, edge_sb.checked);
        $display("Included saturated edges, dropped stray words and random stalls.");
        if (edge_sb.errors == 0 && edge_sb.owed_q.size() == 0) begin
            $display("[sobel_rgb_edge_magnitude_core] OK");
        end else begin
            $display("[sobel_rgb_edge_magnitude_core] ERROR");
        end
        $finish;
    end
endmodule
